@@ design/gaa_pkg.sv @@
// Shared constants, types and the arctangent table for the gimbal aim angle pipeline.
package gaa_pkg;

    // Iterations of each arctangent unit (8 to 24)
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    // Datapath widths
    localparam int CW          = 37;   // CORDIC x/y vector width
    localparam int AW          = 26;   // angle accumulator, 2^-16 degree
    localparam int D_W         = 32;   // square root radicand (high half)
    localparam int SQRT_STAGES = D_W;  // one root bit per stage
    localparam int FRONT_STAGES = 3;   // input, multiply, radius compare
    localparam int PIPE_STAGES  = FRONT_STAGES + SQRT_STAGES + CORDIC_STEPS;

    localparam logic signed [AW-1:0] DEG90  = AW'(5898240);
    localparam logic signed [AW-1:0] DEG180 = AW'(11796480);

    // Operands carried alongside the square root
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [9:0]         off;
        logic               undef;
    } front_t;

    // Flags carried alongside the arctangent units
    typedef struct packed {
        logic x_neg;
        logic z_neg;
        logic undef;
    } back_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] v;
        unique case (i)
            0:       v = AW'(2949120);
            1:       v = AW'(1740967);
            2:       v = AW'(919879);
            3:       v = AW'(466945);
            4:       v = AW'(234379);
            5:       v = AW'(117304);
            6:       v = AW'(58666);
            7:       v = AW'(29335);
            8:       v = AW'(14668);
            9:       v = AW'(7334);
            10:      v = AW'(3667);
            11:      v = AW'(1833);
            12:      v = AW'(917);
            13:      v = AW'(458);
            14:      v = AW'(229);
            15:      v = AW'(115);
            16:      v = AW'(57);
            17:      v = AW'(29);
            18:      v = AW'(14);
            19:      v = AW'(7);
            20:      v = AW'(4);
            21:      v = AW'(2);
            22:      v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/gimbal_aim_angles.sv @@
// Gimbal aim angles: yaw = atan2(x,z), pitch = atan(y/z) - asin(offset/r).
// Pipeline: 3 + 32 + CORDIC_STEPS + 1 registers (16 steps) lie between the accepted input
// item and its valid result in the output register.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset: clears the valid bits, the output valid and the offset register (offset 0).
module gimbal_aim_angles
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // yaw_angle[16:0], pitch_angle[34:17], zero pad
    output logic        m_tuser,   // status
    input  logic        cfg_wen,
    input  logic [9:0]  cfg_wdata
);

    localparam int CW = gaa_pkg::CW;
    localparam int AW = gaa_pkg::AW;
    localparam int NS = gaa_pkg::SQRT_STAGES;
    localparam int NC = gaa_pkg::CORDIC_STEPS;
    localparam int NP = gaa_pkg::PIPE_STAGES;

    logic en;
    logic [9:0] offset_reg;
    logic [NP-1:0] vld_reg;

    // Front stages
    logic signed [15:0] x1_reg, y1_reg, z1_reg;
    logic [9:0]         off1_reg;
    logic signed [15:0] x2_reg, y2_reg, z2_reg;
    logic [9:0]         off2_reg;
    logic [31:0]        yy_reg, zz_reg;
    logic [19:0]        oo_reg;
    logic signed [31:0] ysq, zsq;
    logic [31:0]        r2;
    gaa_pkg::front_t    front_next;
    logic [31:0]        d_next;
    gaa_pkg::front_t    front_reg;
    logic [31:0]        d_reg;

    // Square root stage
    gaa_pkg::front_t    side_reg [NS];
    logic [31:0]        root;
    gaa_pkg::front_t    sq;

    // Arctangent stage operands
    logic signed [16:0]  zabs, ynum;
    logic signed [CW-1:0] yaw_num, yaw_den, th_num, al_num, al_den;
    gaa_pkg::back_t      back_next;
    gaa_pkg::back_t      back_reg [NC];
    logic signed [AW-1:0] yaw_t, theta, alpha;

    // Final stage
    logic signed [AW-1:0] yaw_full, pitch_full, yaw_rnd, pitch_rnd;
    logic                 m_vld_reg;
    logic [16:0]          yaw_reg, yaw_next;
    logic [17:0]          pitch_reg, pitch_next;
    logic                 status_reg;

    // Pipeline advances when the output register can take a new item
    assign en       = !m_vld_reg || m_tready;
    assign s_tready = en;

    // Offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (cfg_wen)
            offset_reg <= cfg_wdata;
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NP-2:0], s_tvalid};
    end

    // Stage 1: capture item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= s_tdata[15:0];
            y1_reg   <= s_tdata[31:16];
            z1_reg   <= s_tdata[47:32];
            off1_reg <= offset_reg;
        end
    end

    // Stage 2: squares
    assign ysq = y1_reg * y1_reg;
    assign zsq = z1_reg * z1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            off2_reg <= off1_reg;
            yy_reg   <= unsigned'(ysq);
            zz_reg   <= unsigned'(zsq);
            oo_reg   <= off1_reg * off1_reg;
        end
    end

    // Stage 3: radius squared, undefined geometry, sqrt radicand
    always_comb
    begin
        r2               = yy_reg + zz_reg;
        front_next.x     = x2_reg;
        front_next.y     = y2_reg;
        front_next.z     = z2_reg;
        front_next.off   = off2_reg;
        front_next.undef = ((y2_reg == '0) && (z2_reg == '0)) || ({12'b0, oo_reg} > r2);
        d_next           = r2 - {12'b0, oo_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
            d_reg     <= d_next;
        end
    end

    // Square root with operands delayed alongside
    gaa_sqrt u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .d    (d_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= front_reg;
            for (int i = 1; i < NS; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    assign sq = side_reg[NS-1];

    // Arctangent operands, scaled by 2^16; left half-plane folded for theta
    always_comb
    begin
        zabs    = sq.z[15] ? -{sq.z[15], sq.z} : {sq.z[15], sq.z};
        ynum    = sq.z[15] ? -{sq.y[15], sq.y} : {sq.y[15], sq.y};
        yaw_num = {{(CW-32){sq.x[15]}}, sq.x, 16'b0};
        yaw_den = {{(CW-33){1'b0}}, zabs, 16'b0};
        th_num  = {{(CW-33){ynum[16]}}, ynum, 16'b0};
        al_num  = {{(CW-26){1'b0}}, sq.off, 16'b0};
        al_den  = {{(CW-32){1'b0}}, root};
        back_next.x_neg = sq.x[15];
        back_next.z_neg = sq.z[15];
        back_next.undef = sq.undef;
    end

    gaa_cordic u_yaw
    (
        .clk (clk),
        .en  (en),
        .num (yaw_num),
        .den (yaw_den),
        .ang (yaw_t)
    );

    gaa_cordic u_theta
    (
        .clk (clk),
        .en  (en),
        .num (th_num),
        .den (yaw_den),
        .ang (theta)
    );

    gaa_cordic u_alpha
    (
        .clk (clk),
        .en  (en),
        .num (al_num),
        .den (al_den),
        .ang (alpha)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            back_reg[0] <= back_next;
            for (int i = 1; i < NC; i++)
                back_reg[i] <= back_reg[i-1];
        end
    end

    // Final: yaw quadrant fix, pitch difference, round to 1/256 degree
    always_comb
    begin
        if (back_reg[NC-1].z_neg)
            yaw_full = back_reg[NC-1].x_neg ? (-gaa_pkg::DEG180 - yaw_t)
                                            : (gaa_pkg::DEG180 - yaw_t);
        else
            yaw_full = yaw_t;
        pitch_full = theta - alpha;
        yaw_rnd    = (yaw_full + AW'(128)) >>> 8;
        pitch_rnd  = (pitch_full + AW'(128)) >>> 8;
        if (back_reg[NC-1].undef)
        begin
            yaw_next   = '0;
            pitch_next = '0;
        end
        else
        begin
            yaw_next   = yaw_rnd[16:0];
            pitch_next = pitch_rnd[17:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= vld_reg[NP-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg    <= yaw_next;
            pitch_reg  <= pitch_next;
            status_reg <= back_reg[NC-1].undef;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'b0, pitch_reg, yaw_reg};
    assign m_tuser  = status_reg;

endmodule

@@ design/gaa_sqrt.sv @@
// Pipelined floor square root of d * 2^32, one result bit per stage.
module gaa_sqrt
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [gaa_pkg::D_W-1:0]   d,
    output logic [gaa_pkg::D_W-1:0]   root
);

    localparam int N  = gaa_pkg::SQRT_STAGES;
    localparam int RW = gaa_pkg::D_W + 2;   // remainder width
    localparam int HALF = gaa_pkg::D_W / 2; // stages that consume radicand bits

    logic [RW-1:0]             rem_reg  [N];
    logic [gaa_pkg::D_W-1:0]   root_reg [N];
    logic [gaa_pkg::D_W-1:0]   d_reg    [HALF];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [RW-1:0]           rem_in;
            logic [gaa_pkg::D_W-1:0] root_in;
            logic [gaa_pkg::D_W-1:0] d_in;
            logic [1:0]              pair;
            logic [RW+1:0]           rem_sh;
            logic [RW+1:0]           trial;
            logic [RW-1:0]           rem_next;
            logic [gaa_pkg::D_W-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign d_in    = d;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                if (k < HALF)
                begin : g_dsrc
                    assign d_in = d_reg[k-1];
                end
                else
                begin : g_dnone
                    assign d_in = '0;
                end
            end

            // Radicand bits come from d for the upper half, zeros below
            if (k < HALF)
            begin : g_pair
                assign pair = d_in[gaa_pkg::D_W-1-2*k -: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            // Restoring trial subtract
            always_comb
            begin
                rem_sh = {rem_in, pair};
                trial  = {2'b00, root_in, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = RW'(rem_sh - trial);
                    root_next = {root_in[gaa_pkg::D_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = RW'(rem_sh);
                    root_next = {root_in[gaa_pkg::D_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end

            if (k < HALF)
            begin : g_dcarry
                always_ff @(posedge clk)
                begin
                    if (en)
                        d_reg[k] <= d_in;
                end
            end
        end
    endgenerate

    assign root = root_reg[N-1];

endmodule

@@ design/gaa_cordic.sv @@
// Pipelined vectoring CORDIC: atan(num/den) for den >= 0, one iteration per stage.
module gaa_cordic
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [gaa_pkg::CW-1:0]     num,
    input  logic signed [gaa_pkg::CW-1:0]     den,
    output logic signed [gaa_pkg::AW-1:0]     ang
);

    localparam int N = gaa_pkg::CORDIC_STEPS;

    logic signed [gaa_pkg::CW-1:0] xv_reg  [N];
    logic signed [gaa_pkg::CW-1:0] yv_reg  [N];
    logic signed [gaa_pkg::AW-1:0] ang_reg [N];
    logic [N-1:0] zero_reg;   // numerator zero: angle is 0
    logic [N-1:0] right_reg;  // denominator zero: angle is +/-90
    logic [N-1:0] neg_reg;    // numerator sign

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic signed [gaa_pkg::CW-1:0] xi;
            logic signed [gaa_pkg::CW-1:0] yi;
            logic signed [gaa_pkg::AW-1:0] ai;
            logic signed [gaa_pkg::CW-1:0] dx;
            logic signed [gaa_pkg::CW-1:0] dy;
            logic signed [gaa_pkg::CW-1:0] x_next;
            logic signed [gaa_pkg::CW-1:0] y_next;
            logic signed [gaa_pkg::AW-1:0] a_next;

            if (k == 0)
            begin : g_first
                assign xi = den;
                assign yi = num;
                assign ai = '0;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        zero_reg[0]  <= (num == '0);
                        right_reg[0] <= (den == '0);
                        neg_reg[0]   <= num[gaa_pkg::CW-1];
                    end
                end
            end
            else
            begin : g_rest
                assign xi = xv_reg[k-1];
                assign yi = yv_reg[k-1];
                assign ai = ang_reg[k-1];
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        zero_reg[k]  <= zero_reg[k-1];
                        right_reg[k] <= right_reg[k-1];
                        neg_reg[k]   <= neg_reg[k-1];
                    end
                end
            end

            // Rotate toward y = 0
            always_comb
            begin
                dx = yi >>> k;
                dy = xi >>> k;
                if (!yi[gaa_pkg::CW-1])
                begin
                    x_next = xi + dx;
                    y_next = yi - dy;
                    a_next = ai + gaa_pkg::atan_tab(k);
                end
                else
                begin
                    x_next = xi - dx;
                    y_next = yi + dy;
                    a_next = ai - gaa_pkg::atan_tab(k);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    xv_reg[k]  <= x_next;
                    yv_reg[k]  <= y_next;
                    ang_reg[k] <= a_next;
                end
            end
        end
    endgenerate

    // Exact answers for an axis-aligned vector
    always_comb
    begin
        priority if (zero_reg[N-1])
            ang = '0;
        else if (right_reg[N-1])
            ang = neg_reg[N-1] ? -gaa_pkg::DEG90 : gaa_pkg::DEG90;
        else
            ang = ang_reg[N-1];
    end

endmodule
